// ===== rtl/sctr_pkg.sv =====
// shared types and constants for the scaled color to rgb converter
`default_nettype none
package sctr_pkg;

	// channel lanes: first, second, third, alpha
	localparam int NUM_CH = 4;
	localparam int CH_W = 16;
	localparam int FRAC_W = 17;
	localparam int CFG_IDX_W = 3;

	// pipeline layout: entry, one stage per quotient bit, four hsb stages
	localparam int DIV_STAGES = 17;
	localparam int ST_H1 = DIV_STAGES + 1;
	localparam int ST_H2 = DIV_STAGES + 2;
	localparam int ST_H3 = DIV_STAGES + 3;
	localparam int ST_OUT = DIV_STAGES + 4;
	localparam int NUM_STAGES = ST_OUT + 1;

	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLOR_MODE   = 3'd0,
		CFG_SCALE_FIRST  = 3'd1,
		CFG_SCALE_SECOND = 3'd2,
		CFG_SCALE_THIRD  = 3'd3,
		CFG_SCALE_ALPHA  = 3'd4
	} cfg_idx_t;

	// hue sectors of the six-sector rule
	typedef enum logic [2:0] {
		SECT_0 = 3'd0,
		SECT_1 = 3'd1,
		SECT_2 = 3'd2,
		SECT_3 = 3'd3,
		SECT_4 = 3'd4,
		SECT_5 = 3'd5
	} sector_t;

endpackage
`default_nettype wire

// ===== rtl/scaled_color_to_rgb_core.sv =====
// scaled color to rgb converter: four scaled channels in, q16 rgba out
//
// Input channel: in_valid/in_ready with chan_first..chan_alpha; an item is
// taken at each edge with both high. Output channel: out_valid/out_ready with
// red_out, green_out, blue_out, alpha_out as unsigned q16 (65536 is 1.0).
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; it is
// always ready and must only be written while no item is in flight.
// Each channel is clamped to its scale and divided by it in a bit-serial
// pipelined divider, one quotient bit per stage (17 stages), then in hsb mode
// hue, saturation and brightness are turned into rgb in four more stages
// (rgb mode passes the fractions through them). One item per cycle is
// sustained while out_ready stays high. Each stage has its own valid bit and
// moves when the stage after it is empty or moving, so a stalled receiver
// only fills bubbles before in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with rgb mode and a
// scale of 255 on every channel.
`default_nettype none
module scaled_color_to_rgb_core #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sctr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sctr_pkg::CH_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [sctr_pkg::CH_W-1:0]              chan_first,
	input  logic [sctr_pkg::CH_W-1:0]              chan_second,
	input  logic [sctr_pkg::CH_W-1:0]              chan_third,
	input  logic [sctr_pkg::CH_W-1:0]              chan_alpha,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [sctr_pkg::FRAC_W-1:0]            red_out,
	output logic [sctr_pkg::FRAC_W-1:0]            green_out,
	output logic [sctr_pkg::FRAC_W-1:0]            blue_out,
	output logic [sctr_pkg::FRAC_W-1:0]            alpha_out
);
	import sctr_pkg::*;

	localparam logic [CH_W-1:0] CHAN_MASK = (CHANNEL_BITS >= CH_W) ? {CH_W{1'b1}} :
		CH_W'((32'd1 << CHANNEL_BITS) - 32'd1);

	// config registers
	logic            mode_q;
	logic [CH_W-1:0] scale_q [NUM_CH];

	// handshake chain
	logic vld [NUM_STAGES];
	logic rdy [NUM_STAGES+1];

	// divider stages
	logic [33:0]       rem_s [DIV_STAGES+1][NUM_CH];
	logic [FRAC_W-1:0] quo_s [DIV_STAGES+1][NUM_CH];

	// hsb stages
	logic [2:0]        sec_s18, sec_s19, sec_s20;
	logic [CH_W-1:0]   f_s18;
	logic [FRAC_W-1:0] c_s18 [NUM_CH];
	logic [FRAC_W-1:0] c_s19 [NUM_CH];
	logic [FRAC_W-1:0] c_s20 [NUM_CH];
	logic [32:0]       k_s19 [3];
	logic [33:0]       hi_s20 [3];
	logic [32:0]       lo_s20 [3];
	logic [FRAC_W-1:0] res_s21 [NUM_CH];

	// combinational helpers
	logic [CH_W-1:0]   sc [NUM_CH];
	logic [FRAC_W-1:0] dvs [NUM_CH];
	logic [CH_W-1:0]   raw [NUM_CH];
	logic [CH_W-1:0]   clmp [NUM_CH];
	logic [FRAC_W-1:0] frac [NUM_CH];
	logic [19:0]       h6;
	logic [2:0]        sec_c;
	logic [32:0]       xs_q, xs_t;
	logic [FRAC_W-1:0] shd [3];

	// config write port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			for (int ch = 0; ch < NUM_CH; ch++) scale_q[ch] <= 16'd255;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COLOR_MODE:   mode_q <= cfg_data[0];
				CFG_SCALE_FIRST:  scale_q[0] <= cfg_data;
				CFG_SCALE_SECOND: scale_q[1] <= cfg_data;
				CFG_SCALE_THIRD:  scale_q[2] <= cfg_data;
				CFG_SCALE_ALPHA:  scale_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// masked scales, divisors and clamped inputs
	assign raw[0] = chan_first;
	assign raw[1] = chan_second;
	assign raw[2] = chan_third;
	assign raw[3] = chan_alpha;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sc[ch] = scale_q[ch] & CHAN_MASK;
			dvs[ch] = {sc[ch], 1'b0};
			clmp[ch] = ((raw[ch] & CHAN_MASK) > sc[ch]) ? sc[ch] : (raw[ch] & CHAN_MASK);
		end
	end

	// ready chain: a stage moves when it is empty or the next one moves
	always_comb begin
		rdy[NUM_STAGES] = out_ready;
		for (int i = NUM_STAGES - 1; i >= 0; i--) rdy[i] = !vld[i] || rdy[i+1];
	end

	assign in_ready = rdy[0];
	assign out_valid = vld[ST_OUT];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STAGES; i++) vld[i] <= 1'b0;
		end else begin
			if (rdy[0]) vld[0] <= in_valid;
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (rdy[i]) vld[i] <= vld[i-1];
			end
		end
	end

	// entry stage and restoring divider, one quotient bit per stage
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				rem_s[0][ch] <= (34'(clmp[ch]) << 17) + 34'(sc[ch]);
				quo_s[0][ch] <= '0;
			end
		end
		for (int k = 1; k <= DIV_STAGES; k++) begin
			if (rdy[k]) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					if (rem_s[k-1][ch] >= (34'(dvs[ch]) << (DIV_STAGES - k))) begin
						rem_s[k][ch] <= rem_s[k-1][ch] - (34'(dvs[ch]) << (DIV_STAGES - k));
						quo_s[k][ch] <= quo_s[k-1][ch] | (17'd1 << (DIV_STAGES - k));
					end else begin
						rem_s[k][ch] <= rem_s[k-1][ch];
						quo_s[k][ch] <= quo_s[k-1][ch];
					end
				end
			end
		end
	end

	// fractions, hue times six, sector and its fraction
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++)
			frac[ch] = (sc[ch] == '0) ? '0 : quo_s[DIV_STAGES][ch];
		h6 = 20'({frac[0], 2'b00}) + 20'({frac[0], 1'b0});
		sec_c = (h6[19:16] >= 4'd6) ? 3'd0 : h6[18:16];
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_H1]) begin
			sec_s18 <= sec_c;
			f_s18 <= h6[15:0];
			for (int ch = 0; ch < NUM_CH; ch++) c_s18[ch] <= frac[ch];
		end
	end

	// x times saturation, and k = 2^32 - x*s for p, q and t
	always_comb begin
		xs_q = 33'(34'(f_s18) * 34'(c_s18[1]));
		xs_t = 33'(34'(ONE_Q16 - 17'(f_s18)) * 34'(c_s18[1]));
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_H2]) begin
			k_s19[0] <= 33'h1_0000_0000 - 33'({c_s18[1], 16'h0000});
			k_s19[1] <= 33'h1_0000_0000 - xs_q;
			k_s19[2] <= 33'h1_0000_0000 - xs_t;
			sec_s19 <= sec_s18;
			for (int ch = 0; ch < NUM_CH; ch++) c_s19[ch] <= c_s18[ch];
		end
	end

	// brightness times k, split into high and low halves of k
	always_ff @(posedge clk) begin
		if (rdy[ST_H3]) begin
			for (int j = 0; j < 3; j++) begin
				hi_s20[j] <= 34'(c_s19[2]) * 34'(k_s19[j][32:16]);
				lo_s20[j] <= 33'(c_s19[2]) * 33'(k_s19[j][15:0]);
			end
			sec_s20 <= sec_s19;
			for (int ch = 0; ch < NUM_CH; ch++) c_s20[ch] <= c_s19[ch];
		end
	end

	// recombine and round: shd holds p, q, t
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic [50:0] sum;
			sum = (51'(hi_s20[j]) << 16) + 51'(lo_s20[j]) + (51'd1 << 31);
			shd[j] = sum[48:32];
		end
	end

	// sector select in hsb mode, or rgb pass-through, into the output register
	always_ff @(posedge clk) begin
		if (rdy[ST_OUT]) begin
			res_s21[3] <= c_s20[3];
			if (!mode_q) begin
				for (int ch = 0; ch < 3; ch++) res_s21[ch] <= c_s20[ch];
			end else begin
				case (sector_t'(sec_s20))
					SECT_0: begin
						res_s21[0] <= c_s20[2]; res_s21[1] <= shd[2]; res_s21[2] <= shd[0];
					end
					SECT_1: begin
						res_s21[0] <= shd[1]; res_s21[1] <= c_s20[2]; res_s21[2] <= shd[0];
					end
					SECT_2: begin
						res_s21[0] <= shd[0]; res_s21[1] <= c_s20[2]; res_s21[2] <= shd[2];
					end
					SECT_3: begin
						res_s21[0] <= shd[0]; res_s21[1] <= shd[1]; res_s21[2] <= c_s20[2];
					end
					SECT_4: begin
						res_s21[0] <= shd[2]; res_s21[1] <= shd[0]; res_s21[2] <= c_s20[2];
					end
					default: begin
						res_s21[0] <= c_s20[2]; res_s21[1] <= shd[0]; res_s21[2] <= shd[1];
					end
				endcase
			end
		end
	end

	assign red_out = res_s21[0];
	assign green_out = res_s21[1];
	assign blue_out = res_s21[2];
	assign alpha_out = res_s21[3];

endmodule
`default_nettype wire

// ===== rtl/sctr_checker.sv =====
// port-level checks for the scaled color to rgb converter
`default_nettype none
module sctr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] red_out,
	input logic [16:0] green_out,
	input logic [16:0] blue_out,
	input logic [16:0] alpha_out
);

	// a waiting item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a waiting item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(alpha_out))
		else $error("output payload changed while stalled");

	// color intensities never exceed one
	a_rgb_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red_out <= 17'd65536 && green_out <= 17'd65536
			&& blue_out <= 17'd65536)
		else $error("rgb output above 1.0");

	// alpha never exceeds one
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alpha_out <= 17'd65536)
		else $error("alpha output above 1.0");

endmodule

bind scaled_color_to_rgb_core sctr_checker u_sctr_checker (.*);
`default_nettype wire

// ===== test/scaled_color_to_rgb_core_test.sv =====
// self-checking testbench for the scaled color to rgb converter core
`timescale 1ns / 1ps
`default_nettype none
module scaled_color_to_rgb_core_test;
	import sctr_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam int ITEMS_PER_SETTING = 165;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [FRAC_W-1:0] red;
		logic [FRAC_W-1:0] green;
		logic [FRAC_W-1:0] blue;
		logic [FRAC_W-1:0] alpha;
	} rgba_t;

	// predicts the converted color and checks results in order
	class rgba_scoreboard;
		logic hsb_mode;
		logic [CH_W-1:0] full_scale [NUM_CH];
		rgba_t pending_rgba [$];
		int errors;

		function void reset_regs();
			hsb_mode = 1'b0;
			foreach (full_scale[i]) full_scale[i] = 16'd255;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CH_W-1:0] data);
			case (idx)
				CFG_COLOR_MODE: hsb_mode = data[0];
				CFG_SCALE_FIRST: full_scale[0] = data;
				CFG_SCALE_SECOND: full_scale[1] = data;
				CFG_SCALE_THIRD: full_scale[2] = data;
				CFG_SCALE_ALPHA: full_scale[3] = data;
				default: ;
			endcase
		endfunction

		// clamp to scale and divide, rounding half up
		function longint unsigned unit_fraction(logic [CH_W-1:0] value, logic [CH_W-1:0] sc);
			longint unsigned v;
			longint unsigned s;
			v = value;
			s = sc;
			if (s == 0) return 0;
			if (v > s) v = s;
			return (v * 65536 * 2 + s) / (2 * s);
		endfunction

		// v * (2^32 - x*s) / 2^32, rounded half up
		function longint unsigned shade(longint unsigned v, longint unsigned x,
				longint unsigned s);
			longint unsigned k;
			k = (64'd1 << 32) - x * s;
			return (v * k + (64'd1 << 31)) >> 32;
		endfunction

		function void note_color(logic [CH_W-1:0] c [NUM_CH]);
			longint unsigned fr [NUM_CH];
			longint unsigned r, g, b, h6, f, p, q, t, s, v;
			sector_t sect;
			rgba_t e;
			foreach (fr[i]) fr[i] = unit_fraction(c[i], full_scale[i]);
			r = fr[0];
			g = fr[1];
			b = fr[2];
			if (hsb_mode) begin
				h6 = fr[0] * 6;
				f = h6 & 64'hFFFF;
				s = fr[1];
				v = fr[2];
				p = shade(v, 65536, s);
				q = shade(v, f, s);
				t = shade(v, 65536 - f, s);
				// hue of exactly one wraps to the first sector
				sect = ((h6 >> 16) >= 6) ? SECT_0 : sector_t'(h6 >> 16);
				case (sect)
					SECT_0: begin r = v; g = t; b = p; end
					SECT_1: begin r = q; g = v; b = p; end
					SECT_2: begin r = p; g = v; b = t; end
					SECT_3: begin r = p; g = q; b = v; end
					SECT_4: begin r = t; g = p; b = v; end
					default: begin r = v; g = p; b = q; end
				endcase
			end
			e.red = r[FRAC_W-1:0];
			e.green = g[FRAC_W-1:0];
			e.blue = b[FRAC_W-1:0];
			e.alpha = fr[3][FRAC_W-1:0];
			pending_rgba.push_back(e);
		endfunction

		function void compare_field(string fname, logic [FRAC_W-1:0] exp_v,
				logic [FRAC_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname,
					exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_rgba(rgba_t got);
			rgba_t e;
			if (pending_rgba.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = pending_rgba.pop_front();
			compare_field("red_out", e.red, got.red);
			compare_field("green_out", e.green, got.green);
			compare_field("blue_out", e.blue, got.blue);
			compare_field("alpha_out", e.alpha, got.alpha);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CH_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [CH_W-1:0] chan_first, chan_second, chan_third, chan_alpha;
	logic out_valid;
	logic out_ready;
	logic [FRAC_W-1:0] red_out, green_out, blue_out, alpha_out;

	rgba_scoreboard sb = new();
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int quiet_cycles;

	scaled_color_to_rgb_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.chan_first(chan_first), .chan_second(chan_second),
		.chan_third(chan_third), .chan_alpha(chan_alpha),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.alpha_out(alpha_out)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver with random stalls and a long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_rgba('{red_out, green_out, blue_out, alpha_out});
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_color(logic [CH_W-1:0] a, logic [CH_W-1:0] b, logic [CH_W-1:0] c,
			logic [CH_W-1:0] d);
		logic [CH_W-1:0] chans [NUM_CH];
		chans = '{a, b, c, d};
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		chan_first <= a;
		chan_second <= b;
		chan_third <= c;
		chan_alpha <= d;
		do @(posedge clk); while (!in_ready);
		sb.note_color(chans);
	endtask

	// lower valid and wait until every result is back, plus pipeline slack
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_rgba.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CH_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_scales(logic [CH_W-1:0] s0, logic [CH_W-1:0] s1,
			logic [CH_W-1:0] s2, logic [CH_W-1:0] s3);
		write_reg(CFG_SCALE_FIRST, s0);
		write_reg(CFG_SCALE_SECOND, s1);
		write_reg(CFG_SCALE_THIRD, s2);
		write_reg(CFG_SCALE_ALPHA, s3);
	endtask

	function automatic logic [CH_W-1:0] pick_scale();
		case ($urandom_range(9))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return 16'd255;
			3: return ($urandom_range(19) == 0) ? 16'd0 : 16'd6;
			4, 5: return 16'($urandom_range(2, 1023));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	// channel values biased toward zero, the scale and its neighbors
	function automatic logic [CH_W-1:0] pick_chan(logic [CH_W-1:0] sc);
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return sc;
			3: return 16'(sc + $urandom_range(2) - 1);
			4, 5: return 16'($urandom_range(65535));
			default: return (sc == 0) ? 16'(0) : 16'($urandom_range(sc));
		endcase
	endfunction

	task automatic random_colors(int n);
		repeat (n)
			send_color(pick_chan(sb.full_scale[0]), pick_chan(sb.full_scale[1]),
				pick_chan(sb.full_scale[2]), pick_chan(sb.full_scale[3]));
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		chan_first = '0;
		chan_second = '0;
		chan_third = '0;
		chan_alpha = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		sb.reset_regs();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// rgb mode with reset scales: zero, clamp, rounding
		send_color(16'd0, 16'd0, 16'd0, 16'd0);
		send_color(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_color(16'd255, 16'd256, 16'd254, 16'd1);
		send_color(16'd128, 16'd127, 16'd3, 16'd170);
		drain();

		// hsb mode, upper data bits dropped
		write_reg(CFG_COLOR_MODE, 16'hFFFF);
		send_color(16'd0, 16'd255, 16'd255, 16'd255);
		send_color(16'd43, 16'd255, 16'd255, 16'd0);
		send_color(16'd85, 16'd200, 16'd255, 16'd9);
		send_color(16'd128, 16'd255, 16'd100, 16'd50);
		send_color(16'd170, 16'd128, 16'd255, 16'd255);
		send_color(16'd213, 16'd255, 16'd77, 16'd255);
		// hue of one wraps, zero saturation, zero brightness
		send_color(16'd255, 16'd255, 16'd255, 16'd255);
		send_color(16'd300, 16'd0, 16'd200, 16'd1);
		send_color(16'd100, 16'd255, 16'd0, 16'd2);
		drain();

		// indexes beyond the register list are ignored
		for (int i = CFG_SCALE_ALPHA + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), 16'($urandom_range(65535)));
		// zero scales give zero fractions
		write_scales(16'd0, 16'd0, 16'd0, 16'd0);
		send_color(16'd5, 16'hFFFF, 16'd0, 16'd1);
		drain();
		write_scales(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_color(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
		send_color(16'h7FFF, 16'h0001, 16'hAAAA, 16'h5555);
		drain();
		write_scales(16'd1, 16'd1, 16'd1, 16'd1);
		send_color(16'd1, 16'd1, 16'd1, 16'd0);
		send_color(16'd0, 16'd1, 16'd1, 16'd1);
		drain();

		// random phases under three idle profiles
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 57 : 0;
			recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 22 : 0;
			for (int k = 0; k < 3; k++) begin
				write_reg(CFG_COLOR_MODE, 16'($urandom_range(65535)));
				write_scales(pick_scale(), pick_scale(), pick_scale(), pick_scale());
				random_colors(ITEMS_PER_SETTING);
				if (ph == 2 && k == 0) begin
					// long receiver hold-off while the sender keeps offering
					hold_left = HOLD_CYCLES;
					random_colors(60);
				end
				drain();
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending_rgba.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
